// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BGCD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bgcd assertion failed");

// Checked on every edge, reset included.
`define BGCD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("bgcd assertion failed");

`endif

// ===== rtl/bgcd_pkg.sv =====
package bgcd_pkg;

    // Command broadcast to every cell of the row
    typedef logic [2:0] t_op;

    localparam t_op OP_HOLD     = 3'd0;
    localparam t_op OP_LOAD     = 3'd1;
    localparam t_op OP_SHR_BOTH = 3'd2;
    localparam t_op OP_SHR_X    = 3'd3;
    localparam t_op OP_SHR_Y    = 3'd4;
    localparam t_op OP_SUB_X    = 3'd5;  // x <= x - y
    localparam t_op OP_SUB_Y    = 3'd6;  // y <= y - x
    localparam t_op OP_SHL_X    = 3'd7;

    // Status gathered from the row for the sequencer
    typedef struct packed {
        logic eq;
        logic x_odd;
        logic y_odd;
        logic x_gt_y;
    } t_status;

endpackage

// ===== rtl/bgcd_cell.sv =====
module bgcd_cell (
    input  logic           i_clk,
    input  bgcd_pkg::t_op  i_op,
    input  logic           i_load_x,
    input  logic           i_load_y,
    input  logic           i_hi_x,
    input  logic           i_hi_y,
    input  logic           i_lo_x,
    input  logic           i_bx,
    input  logic           i_by,
    output logic           o_x,
    output logic           o_y,
    output logic           o_bx,
    output logic           o_by
);
    import bgcd_pkg::*;

    logic r_x;
    logic r_y;
    logic n_x;
    logic n_y;
    logic dx;
    logic dy;

    // one bit of x - y and of y - x, borrows ripple upward
    assign dx   = r_x ^ r_y ^ i_bx;
    assign o_bx = (~r_x & r_y) | (~(r_x ^ r_y) & i_bx);
    assign dy   = r_y ^ r_x ^ i_by;
    assign o_by = (~r_y & r_x) | (~(r_x ^ r_y) & i_by);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_x = i_load_x;
                n_y = i_load_y;
            end
            OP_SHR_BOTH: begin
                n_x = i_hi_x;
                n_y = i_hi_y;
            end
            OP_SHR_X: n_x = i_hi_x;
            OP_SHR_Y: n_y = i_hi_y;
            OP_SUB_X: n_x = dx;
            OP_SUB_Y: n_y = dy;
            OP_SHL_X: n_x = i_lo_x;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== rtl/bgcd_ctrl.sv =====
module bgcd_ctrl #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_zero_in,
    input  bgcd_pkg::t_status i_status,
    output bgcd_pkg::t_op     o_op,
    output logic              o_busy,
    output logic              o_capture_x,
    output logic              o_capture_in
);
    import bgcd_pkg::*;

    localparam int TW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STRIP  = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [TW-1:0] r_twos;
    logic [TW-1:0] n_twos;
    logic          accept;

    assign accept = i_start & (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_twos       = r_twos;
        o_op         = OP_HOLD;
        o_capture_x  = 1'b0;
        o_capture_in = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_zero_in) begin
                        o_capture_in = 1'b1;
                    end else begin
                        o_op    = OP_LOAD;
                        n_twos  = '0;
                        n_state = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                if (!i_status.x_odd && !i_status.y_odd) begin
                    o_op   = OP_SHR_BOTH;
                    n_twos = r_twos + 1'b1;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.eq) begin
                    n_state = (r_twos == '0) ? S_FINISH : S_SCALE;
                end else if (!i_status.x_odd) begin
                    o_op = OP_SHR_X;
                end else if (!i_status.y_odd) begin
                    o_op = OP_SHR_Y;
                end else if (i_status.x_gt_y) begin
                    o_op = OP_SUB_X;
                end else begin
                    o_op = OP_SUB_Y;
                end
            end
            S_SCALE: begin
                o_op   = OP_SHL_X;
                n_twos = r_twos - 1'b1;
                if (r_twos == TW'(1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_capture_x = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_twos  <= '0;
        end else begin
            r_state <= n_state;
            r_twos  <= n_twos;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/binary_gcd_core.sv =====
// Binary GCD core (Stein's method) built as a row of one-bit cells.
// Command channel: present i_first_operand / i_second_operand with start;
// the pair is taken at a rising edge where start is high and busy is low.
// The result is shown on o_divisor_result for exactly one cycle, marked by
// o_valid; the receiver cannot stall it, so it must take that beat.
// Sequence: when either operand is zero the answer (the other operand) is
// strobed the cycle after the accept and busy never rises. Otherwise the
// row loads, strips the common factors of two, runs the shift/subtract
// steps plus a final compare, shifts the factors of two back in and
// captures x in a finish state; the strobe is registered from that
// capture. The cell row does one shift/subtract step per cycle.
// busy drops in the strobe cycle, so a new pair may be taken alongside
// the result beat. Sync reset clears the sequencer and the strobe;
// operand bits held in the cells need no reset.
module binary_gcd_core #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPERAND_WIDTH-1:0] i_first_operand,
    input  logic [OPERAND_WIDTH-1:0] i_second_operand,
    output logic [OPERAND_WIDTH-1:0] o_divisor_result,
    output logic                     o_valid
);
    import bgcd_pkg::*;

    t_op                    op;
    t_status                status;
    logic [OPERAND_WIDTH-1:0] x_bus;
    logic [OPERAND_WIDTH-1:0] y_bus;
    logic [OPERAND_WIDTH:0]   bx_chain;
    logic [OPERAND_WIDTH:0]   by_chain;
    logic                     zero_in;
    logic                     capture_x;
    logic                     capture_in;
    logic [OPERAND_WIDTH-1:0] r_result;
    logic                     r_valid;

    assign zero_in = (i_first_operand == '0) || (i_second_operand == '0);

    assign bx_chain[0] = 1'b0;
    assign by_chain[0] = 1'b0;

    for (genvar g = 0; g < OPERAND_WIDTH; g++) begin : g_cell
        logic hi_x;
        logic hi_y;
        logic lo_x;

        if (g == OPERAND_WIDTH - 1) begin : g_top
            assign hi_x = 1'b0;
            assign hi_y = 1'b0;
        end else begin : g_mid
            assign hi_x = x_bus[g+1];
            assign hi_y = y_bus[g+1];
        end

        if (g == 0) begin : g_bot
            assign lo_x = 1'b0;
        end else begin : g_up
            assign lo_x = x_bus[g-1];
        end

        bgcd_cell u_cell (
            .i_clk    (i_clk),
            .i_op     (op),
            .i_load_x (i_first_operand[g]),
            .i_load_y (i_second_operand[g]),
            .i_hi_x   (hi_x),
            .i_hi_y   (hi_y),
            .i_lo_x   (lo_x),
            .i_bx     (bx_chain[g]),
            .i_by     (by_chain[g]),
            .o_x      (x_bus[g]),
            .o_y      (y_bus[g]),
            .o_bx     (bx_chain[g+1]),
            .o_by     (by_chain[g+1])
        );
    end

    // no borrow out of either difference means x == y
    assign status.eq     = ~bx_chain[OPERAND_WIDTH] & ~by_chain[OPERAND_WIDTH];
    assign status.x_odd  = x_bus[0];
    assign status.y_odd  = y_bus[0];
    // borrow out of y - x means y < x
    assign status.x_gt_y = by_chain[OPERAND_WIDTH];

    bgcd_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_zero_in    (zero_in),
        .i_status     (status),
        .o_op         (op),
        .o_busy       (busy),
        .o_capture_x  (capture_x),
        .o_capture_in (capture_in)
    );

    always_ff @(posedge i_clk) begin
        if (capture_x) begin
            r_result <= x_bus;
        end else if (capture_in) begin
            r_result <= i_first_operand | i_second_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= capture_x | capture_in;
        end
    end

    assign o_divisor_result = r_result;
    assign o_valid          = r_valid;

endmodule

// ===== rtl/bgcd_checker.sv =====
`include "assert_macros.svh"

module bgcd_checker #(
    parameter int OPERAND_WIDTH = 31
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [OPERAND_WIDTH-1:0] i_first_operand,
    input logic [OPERAND_WIDTH-1:0] i_second_operand,
    input logic [OPERAND_WIDTH-1:0] o_divisor_result,
    input logic                     o_valid
);

    logic                     take_zero;
    logic [OPERAND_WIDTH-1:0] zero_pair;

    assign take_zero = start && !busy
                       && ((i_first_operand == '0) || (i_second_operand == '0));
    assign zero_pair = i_first_operand | i_second_operand;

    // a zero operand gives the other one back on the next beat
    property p_zero_pass;
        take_zero |=> o_valid && !busy && (o_divisor_result == $past(zero_pair));
    endproperty

    `BGCD_ASSERT(a_zero_pass, i_clk, i_rst_n, p_zero_pass)
    // a nonzero pair keeps the core busy
    `BGCD_ASSERT(a_busy_rise, i_clk, i_rst_n, (start && !busy && !take_zero) |=> busy && !o_valid)
    // the end of a run always carries a result beat
    `BGCD_ASSERT(a_fall_valid, i_clk, i_rst_n, $fell(busy) |-> o_valid)
    `BGCD_ASSERT(a_valid_idle, i_clk, i_rst_n, o_valid |-> !busy)
    `BGCD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !busy)

endmodule

bind binary_gcd_core bgcd_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_bgcd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_first_operand  (i_first_operand),
    .i_second_operand (i_second_operand),
    .o_divisor_result (o_divisor_result),
    .o_valid          (o_valid)
);
